@@ sv/i2cms_pkg.sv @@
// Shared types and constants for the I2C master bit sequencer.
package i2cms_pkg;

   // Command codes
   localparam logic [2:0] CMD_START    = 3'd0;
   localparam logic [2:0] CMD_STOP     = 3'd1;
   localparam logic [2:0] CMD_SEND     = 3'd2;
   localparam logic [2:0] CMD_RECV     = 3'd3;
   localparam logic [2:0] CMD_ACK      = 3'd4;
   localparam logic [2:0] CMD_NACK     = 3'd5;
   localparam logic [2:0] CMD_WAIT_ACK = 3'd6;
   localparam logic [2:0] CMD_UNUSED   = 3'd7;

   localparam int unsigned DELAY_W     = 16;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd240;

   localparam int unsigned IDX_W       = 5;
   localparam logic [IDX_W-1:0] SEND_LAST = 5'd24;
   localparam logic [IDX_W-1:0] RECV_LAST = 5'd17;

   localparam logic [1:0] SUB_IDLE  = 2'd0;
   localparam logic [1:0] SUB_DATA  = 2'd1;
   localparam logic [1:0] SUB_CLOCK = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       hold;
      logic       sample;
      logic       last;
      logic [7:0] rx;
      logic       ack;
   } phase_type;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [IDX_W-1:0] idx;
      logic [1:0]       sub;
      logic             tx_msb;
      logic             scl_now;
      logic             sda_now;
      logic [7:0]       line;
   } phase_ctx_type;

endpackage

@@ sv/i2cms_timer.sv @@
// Delay unit down counter shared by every held phase.
module i2cms_timer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [i2cms_pkg::DELAY_W-1:0]   delay_ticks,
   output logic                            done
);
   import i2cms_pkg::*;

   logic [DELAY_W-1:0] cnt_ff;
   logic [DELAY_W-1:0] cnt_in;

   always_comb begin
      if (start) begin
         cnt_in = delay_ticks;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - {{(DELAY_W-1){1'b0}}, 1'b1};
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // a zero delay behaves like a delay of one
   assign done = (cnt_ff <= {{(DELAY_W-1){1'b0}}, 1'b1});

endmodule

@@ sv/i2cms_phase_gen.sv @@
// Phase table: pin levels and flags of the current phase of a command.
module i2cms_phase_gen (
   input  i2cms_pkg::phase_ctx_type ctx,
   output i2cms_pkg::phase_type     phase
);
   import i2cms_pkg::*;

   logic d_bit;

   assign d_bit = (ctx.cmd == CMD_NACK);

   always_comb begin
      phase = '0;
      unique case (ctx.cmd)
         CMD_START: begin
            unique case (ctx.idx[1:0])
               2'd0: begin
                  phase.scl = ctx.scl_now;
                  phase.sda = 1'b1;
               end
               2'd1: begin
                  phase.scl  = 1'b1;
                  phase.sda  = 1'b1;
                  phase.hold = 1'b1;
               end
               2'd2: begin
                  phase.scl  = 1'b1;
                  phase.hold = 1'b1;
               end
               default: begin
                  phase.scl  = 1'b1;
                  phase.hold = 1'b1;
                  phase.last = 1'b1;
               end
            endcase
         end
         CMD_STOP: begin
            phase.hold = 1'b1;
            unique case (ctx.idx[1:0])
               2'd0: phase.sda = ctx.sda_now;
               2'd1: phase.sda = 1'b0;
               2'd2: phase.scl = 1'b1;
               default: begin
                  phase.scl  = 1'b1;
                  phase.sda  = 1'b1;
                  phase.last = 1'b1;
               end
            endcase
         end
         CMD_ACK, CMD_NACK: begin
            phase.hold = 1'b1;
            unique case (ctx.idx[1:0])
               2'd0: phase.sda = ctx.sda_now;
               2'd1: phase.sda = d_bit;
               2'd2: begin
                  phase.scl = 1'b1;
                  phase.sda = d_bit;
               end
               default: begin
                  phase.sda  = d_bit;
                  phase.last = 1'b1;
               end
            endcase
         end
         CMD_WAIT_ACK: begin
            phase.sda = 1'b1;
            unique case (ctx.idx[1:0])
               2'd0: begin
                  phase.sda  = ctx.sda_now;
                  phase.hold = 1'b1;
               end
               2'd1: phase.hold = 1'b1;
               2'd2: begin
                  phase.scl    = 1'b1;
                  phase.hold   = 1'b1;
                  phase.sample = 1'b1;
               end
               default: begin
                  phase.last = 1'b1;
                  phase.ack  = ~ctx.line[0];
               end
            endcase
         end
         CMD_SEND: begin
            if (ctx.idx == SEND_LAST) begin
               // sda_now already holds the last data bit
               phase.sda  = ctx.sda_now;
               phase.last = 1'b1;
            end else begin
               phase.hold = 1'b1;
               unique case (ctx.sub)
                  SUB_DATA: phase.sda = ctx.tx_msb;
                  SUB_CLOCK: begin
                     phase.scl = 1'b1;
                     phase.sda = ctx.tx_msb;
                  end
                  default: phase.sda = ctx.sda_now;
               endcase
            end
         end
         CMD_RECV: begin
            phase.sda = 1'b1;
            priority if (ctx.idx == '0) begin
               phase.scl = ctx.scl_now;
            end else if (ctx.idx == RECV_LAST) begin
               phase.last = 1'b1;
               phase.rx   = ctx.line;
            end else if (ctx.idx[0]) begin
               phase.hold = 1'b1;
            end else begin
               phase.scl    = 1'b1;
               phase.hold   = 1'b1;
               phase.sample = 1'b1;
            end
         end
         default: phase = '0;
      endcase
   end

endmodule

@@ sv/i2c_master_bit_sequencer.sv @@
// I2C master bit sequencer top level: command intake, phase sequencer, delay timer.
//
// Each accepted command expands into a run of SCL/SDA pin phases, one result
// item per phase: start, stop, ack, no-ack and wait-ack give 4 phases, send
// byte 25 and receive byte 18. The block takes one command at a time and
// holds req_stall high until the last phase of its run has been taken and,
// if held, its delay unit has run out. A phase with hold set is followed by
// one delay unit set by the delay register (written from csr_write_data; a
// zero value acts as one), timed by a single shared down counter; every phase
// is also presented on the result port and stays there while rsp_stall is
// high. Of the phases, 3 are held for start and wait-ack, 4 for stop, ack and
// no-ack, 24 for send byte and 16 for receive byte. Command code 7 is taken
// and dropped with no phases. Write the delay register only while idle.
// SCL and SDA levels of the last phase are kept across commands (both high
// after reset).
module i2c_master_bit_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_tx_byte,
   input  logic [7:0]  req_line_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_hold_units,
   output logic        rsp_sample_point,
   output logic        rsp_last_phase,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_seen,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import i2cms_pkg::*;

   state_type          state_ff, state_in;
   logic [DELAY_W-1:0] delay_ff;
   logic               scl_now_ff, sda_now_ff;
   logic [2:0]         cmd_ff;
   logic [7:0]         tx_ff, line_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [1:0]         sub_ff;
   logic               done_ff;

   logic               req_take, rsp_take;
   logic               timer_start, timer_done;
   phase_ctx_type      ctx;
   phase_type          phase;

   assign req_take    = req_valid && !req_stall;
   assign rsp_take    = rsp_valid && !rsp_stall;
   // held phases kick the shared timer as they leave the port
   assign timer_start = rsp_take && phase.hold;

   // ---- phase lookup ----
   assign ctx.cmd     = cmd_ff;
   assign ctx.idx     = idx_ff;
   assign ctx.sub     = sub_ff;
   assign ctx.tx_msb  = tx_ff[7];
   assign ctx.scl_now = scl_now_ff;
   assign ctx.sda_now = sda_now_ff;
   assign ctx.line    = line_ff;

   i2cms_phase_gen u_phase_gen (
      .ctx   (ctx),
      .phase (phase)
   );

   i2cms_timer u_timer (
      .clock       (clock),
      .reset       (reset),
      .start       (timer_start),
      .delay_ticks (delay_ff),
      .done        (timer_done)
   );

   // ---- sequencer: next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_cmd != CMD_UNUSED) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               priority if (phase.hold) begin
                  state_in = ST_HOLD;
               end else if (phase.last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_HOLD: begin
            if (timer_done) begin
               state_in = done_ff ? ST_IDLE : ST_EMIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- sequencer: outputs ----
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_EMIT: rsp_valid = 1'b1;
         ST_HOLD: rsp_valid = 1'b0;
         default: req_stall = 1'b1;
      endcase
   end

   assign rsp_scl_level    = phase.scl;
   assign rsp_sda_level    = phase.sda;
   assign rsp_hold_units   = phase.hold;
   assign rsp_sample_point = phase.sample;
   assign rsp_last_phase   = phase.last;
   assign rsp_rx_byte      = phase.rx;
   assign rsp_ack_seen     = phase.ack;

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         delay_ff   <= DELAY_RESET;
         scl_now_ff <= 1'b1;
         sda_now_ff <= 1'b1;
         done_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            delay_ff <= csr_write_data;
         end
         if (rsp_take) begin
            scl_now_ff <= phase.scl;
            sda_now_ff <= phase.sda;
            done_ff    <= phase.last;
         end
      end
   end

   // ---- item registers ----
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff  <= req_cmd;
         tx_ff   <= req_tx_byte;
         line_ff <= req_line_bits;
         idx_ff  <= '0;
         sub_ff  <= SUB_IDLE;
      end else if (rsp_take) begin
         idx_ff <= idx_ff + {{(IDX_W-1){1'b0}}, 1'b1};
         // send byte: three phases per bit, shift after the clock-high phase
         if (sub_ff == SUB_CLOCK) begin
            sub_ff <= SUB_IDLE;
            tx_ff  <= {tx_ff[6:0], 1'b0};
         end else begin
            sub_ff <= sub_ff + 2'd1;
         end
      end
   end

endmodule

@@ sv/i2cms_checker.sv @@
// Port-level checks for the I2C master bit sequencer, bound to the top level.
module i2cms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_cmd,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_scl_level,
   input logic        rsp_sda_level,
   input logic        rsp_hold_units,
   input logic        rsp_sample_point,
   input logic        rsp_last_phase,
   input logic [7:0]  rsp_rx_byte,
   input logic        rsp_ack_seen
);
   import i2cms_pkg::*;

   // a real command blocks intake in the next cycle
   a_cmd_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd != CMD_UNUSED |=> req_stall)
      else $error("intake open right after a command was taken");

   // no command is taken while a phase is on the result port
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("intake open while a phase is pending");

   // SDA is only sampled with SCL high
   a_sample_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_point |-> rsp_scl_level)
      else $error("sample point with SCL low");

   // received byte and ack only show on a final phase
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_phase |-> rsp_rx_byte == 8'd0 && !rsp_ack_seen)
      else $error("status field set before the final phase");

   // a stalled phase holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scl_level)
         && $stable(rsp_sda_level) && $stable(rsp_hold_units)
         && $stable(rsp_last_phase))
      else $error("stalled phase changed");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_checker (.*);
